>>> rtl/ifn_pkg.sv
`timescale 1ns / 1ps

package ifn_pkg;

   // Opcodes of a request.
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_APPEND = 1'b1;

   // Source kinds of a synapse.
   localparam logic [1:0] SRC_NEURON = 2'd0;
   localparam logic [1:0] SRC_FOOD   = 2'd1;
   localparam logic [1:0] SRC_ENERGY = 2'd2;
   localparam logic [1:0] SRC_OTHER  = 2'd3;

   // Neuron kinds.
   localparam logic [2:0] KIND_PLAIN   = 3'd0;
   localparam logic [2:0] KIND_FORWARD = 3'd1;
   localparam logic [2:0] KIND_LEFT    = 3'd2;
   localparam logic [2:0] KIND_RIGHT   = 3'd3;
   localparam logic [2:0] KIND_FOOD    = 3'd4;
   localparam logic [2:0] KIND_ENERGY  = 3'd5;

   // Impulse codes.
   localparam logic [1:0] IMP_NONE    = 2'd0;
   localparam logic [1:0] IMP_FORWARD = 2'd1;
   localparam logic [1:0] IMP_LEFT    = 2'd2;
   localparam logic [1:0] IMP_RIGHT   = 2'd3;

   // Configuration register indexes.
   localparam int         CSR_INDEX_W   = 1;
   localparam logic       CSR_THRESHOLD = 1'b0;
   localparam logic       CSR_KIND      = 1'b1;

   localparam logic signed [31:0] THRESHOLD_RESET = 32'sd65536;

   // 1.0 in Q8.8, wide enough for one minus any sensor value.
   localparam logic signed [17:0] ONE_Q8_8 = 18'sd256;

   // Number of presynaptic fired bits carried by a request.
   localparam int PRESYN_BITS = 16;

   typedef struct packed {
      logic               opcode;
      logic [15:0]        presyn_fired;
      logic signed [15:0] food_level;
      logic signed [15:0] energy_level;
      logic signed [15:0] syn_weight;
      logic               syn_inverted;
      logic [1:0]         syn_source;
   } req_type;

   typedef struct packed {
      logic               fired;
      logic [1:0]         impulse;
      logic signed [31:0] potential;
      logic               table_full;
      logic [4:0]         synapse_count;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] weight;
      logic               inverted;
      logic [1:0]         source;
   } synapse_type;

   typedef struct packed {
      logic mul_en;
      logic acc_en;
      logic clear;
   } mac_ctl_type;

endpackage

>>> rtl/ifn_ram.sv
`timescale 1ns / 1ps

module ifn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/ifn_mac.sv
`timescale 1ns / 1ps

module ifn_mac import ifn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  mac_ctl_type        ctl,
   input  synapse_type        entry,
   input  logic               presyn_bit,
   input  logic signed [15:0] food,
   input  logic signed [15:0] energy,
   output logic signed [31:0] membrane
);

   logic signed [17:0] src_value;
   logic signed [17:0] term;
   logic signed [33:0] prod_in;
   logic signed [33:0] prod_ff;
   logic signed [34:0] sum;
   logic signed [31:0] membrane_in;
   logic signed [31:0] membrane_ff;

   // Source value in Q8.8, then the optional one-minus.
   always_comb begin
      case (entry.source)
         SRC_NEURON: src_value = presyn_bit ? ONE_Q8_8 : 18'sd0;
         SRC_FOOD:   src_value = 18'(food);
         SRC_ENERGY: src_value = 18'(energy);
         default:    src_value = 18'sd0;
      endcase
      term    = entry.inverted ? 18'(ONE_Q8_8 - src_value) : src_value;
      prod_in = term * $signed(entry.weight);
   end

   // Saturating add: overflow shows as the top four bits disagreeing.
   always_comb begin
      sum = 35'(membrane_ff) + 35'(prod_ff);
      membrane_in = membrane_ff;
      if (ctl.clear) begin
         membrane_in = 32'sd0;
      end else if (ctl.acc_en) begin
         if (sum[34:31] == 4'b0000 || sum[34:31] == 4'b1111) begin
            membrane_in = sum[31:0];
         end else if (sum[34]) begin
            membrane_in = {1'b1, 31'd0};
         end else begin
            membrane_in = {1'b0, {31{1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         membrane_ff <= 32'sd0;
      end else begin
         membrane_ff <= membrane_in;
      end
   end

   assign membrane = membrane_ff;

endmodule

>>> rtl/integrate_fire_neuron_top.sv
`timescale 1ns / 1ps
// An append request, or a tick on which the neuron fired before, answers in the cycle after
// it is taken, and busy stays low, so such requests may follow every cycle.
// A tick that integrates stored synapses streams them through the table read, multiply and
// accumulate stages, answering once they drain; an empty table or sensor kind skips them.
// Busy is high until the answer; the sequencer state sets this. Reset is
// synchronous, active high: empty table, zero membrane and fired flag, threshold 1.0.

module integrate_fire_neuron_top import ifn_pkg::*; #(
   parameter int MAX_SYNAPSES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);

   // Address width of the synapse table and width of the fill count.
   localparam int AW = (MAX_SYNAPSES > 1) ? $clog2(MAX_SYNAPSES) : 1;
   localparam int CW = $clog2(MAX_SYNAPSES + 1);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_WAIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic signed [31:0] threshold_ff;
   logic [2:0]         kind_ff;

   // Operands of the tick in progress, captured when the request is taken.
   logic [15:0]        presyn_ff, presyn_in;
   logic signed [15:0] food_ff, food_in;
   logic signed [15:0] energy_ff, energy_in;

   // Neuron and table state.
   logic               fired_ff, fired_in;
   logic [CW-1:0]      count_ff, count_in;

   // Sequencer: slot being read, and the valid flags of the read and multiply stages.
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      idx_next;
   logic               rd_v_ff, rd_v_in;
   logic [CW-1:0]      rd_idx_ff, rd_idx_in;
   logic               mul_v_ff;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Table and arithmetic unit connections.
   logic               tbl_we;
   synapse_type        tbl_wdata;
   synapse_type        tbl_rdata;
   logic [AW-1:0]      tbl_raddr;
   mac_ctl_type        mac_ctl;
   logic               presyn_bit;
   logic [6:0]         rd_idx_w;
   logic signed [31:0] membrane;

   logic               accept;
   logic               table_has_room;
   logic               integrates;
   logic               fire;
   logic [1:0]         impulse_code;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign table_has_room = (count_ff < CW'(MAX_SYNAPSES));
   assign idx_next       = CW'(idx_ff + 1'b1);

   // Sensor kinds only compare against the threshold; every other kind integrates.
   assign integrates = !(kind_ff == KIND_FOOD || kind_ff == KIND_ENERGY);

   // Activator kinds report their direction when they fire.
   always_comb begin
      case (kind_ff)
         KIND_FORWARD: impulse_code = IMP_FORWARD;
         KIND_LEFT:    impulse_code = IMP_LEFT;
         KIND_RIGHT:   impulse_code = IMP_RIGHT;
         default:      impulse_code = IMP_NONE;
      endcase
   end

   // Slots beyond the width of the presynaptic vector see a zero fired bit.
   assign rd_idx_w   = 7'(rd_idx_ff);
   assign presyn_bit = (rd_idx_w < 7'(PRESYN_BITS)) ? presyn_ff[rd_idx_w[3:0]] : 1'b0;

   assign tbl_wdata.weight   = req_data.syn_weight;
   assign tbl_wdata.inverted = req_data.syn_inverted;
   assign tbl_wdata.source   = req_data.syn_source;
   assign tbl_raddr          = idx_ff[AW-1:0];

   // The threshold compare happens once the accumulation pipeline has drained.
   assign fire = (state_ff == ST_WAIT) && !rd_v_ff && !mul_v_ff && (membrane >= threshold_ff);

   assign mac_ctl.mul_en = rd_v_ff;
   assign mac_ctl.acc_en = mul_v_ff;
   assign mac_ctl.clear  = fire;

   always_comb begin
      state_in     = state_ff;
      presyn_in    = presyn_ff;
      food_in      = food_ff;
      energy_in    = energy_ff;
      fired_in     = fired_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rd_v_in      = 1'b0;
      rd_idx_in    = rd_idx_ff;
      tbl_we       = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_data_in.impulse    = IMP_NONE;
               rsp_data_in.potential  = membrane;
               rsp_data_in.table_full = 1'b0;
               if (req_data.opcode == OP_APPEND) begin
                  // An append either fills the next slot or is refused when the table is full.
                  if (table_has_room) begin
                     tbl_we   = 1'b1;
                     count_in = CW'(count_ff + 1'b1);
                  end else begin
                     rsp_data_in.table_full = 1'b1;
                  end
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.fired         = fired_ff;
                  rsp_data_in.synapse_count = 5'(count_in);
               end else if (fired_ff) begin
                  // The tick after a firing only clears the fired flag.
                  fired_in                  = 1'b0;
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.fired         = 1'b0;
                  rsp_data_in.synapse_count = 5'(count_ff);
               end else begin
                  presyn_in = req_data.presyn_fired;
                  food_in   = req_data.food_level;
                  energy_in = req_data.energy_level;
                  idx_in    = '0;
                  if (integrates && count_ff != '0) begin
                     state_in = ST_RUN;
                  end else begin
                     state_in = ST_WAIT;
                  end
               end
            end
         end
         ST_RUN: begin
            // One table read per cycle feeds the multiplier stage.
            rd_v_in   = 1'b1;
            rd_idx_in = idx_ff;
            idx_in    = idx_next;
            if (idx_next == count_ff) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (!rd_v_ff && !mul_v_ff) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.fired         = fire;
               rsp_data_in.impulse       = fire ? impulse_code : IMP_NONE;
               rsp_data_in.potential     = fire ? 32'sd0 : membrane;
               rsp_data_in.table_full    = 1'b0;
               rsp_data_in.synapse_count = 5'(count_ff);
               fired_in                  = fire;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         threshold_ff <= THRESHOLD_RESET;
         kind_ff      <= KIND_PLAIN;
         fired_ff     <= 1'b0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rd_v_ff      <= 1'b0;
         mul_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fired_ff     <= fired_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rd_v_ff      <= rd_v_in;
         mul_v_ff     <= rd_v_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_THRESHOLD: threshold_ff <= csr_wdata;
               CSR_KIND:      kind_ff      <= csr_wdata[2:0];
               default:       kind_ff      <= kind_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      presyn_ff   <= presyn_in;
      food_ff     <= food_in;
      energy_ff   <= energy_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Synapse table: written at the fill count, read by the sequencer one slot per cycle.
   ifn_ram #(
      .WIDTH ($bits(synapse_type)),
      .DEPTH (MAX_SYNAPSES)
   ) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (count_ff[AW-1:0]),
      .wdata (tbl_wdata),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   // Shared multiply-accumulate unit; it also holds the membrane potential.
   ifn_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mac_ctl),
      .entry      (tbl_rdata),
      .presyn_bit (presyn_bit),
      .food       (food_ff),
      .energy     (energy_ff),
      .membrane   (membrane)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The fill count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SYNAPSES))
      else $error("synapse count exceeds table depth");

   // The sequencer only reads slots that have been written.
   a_read_in_table: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> idx_ff < count_ff)
      else $error("sequencer reads beyond the fill count");

   // Work in the accumulation pipeline only exists while a tick is in progress.
   a_pipe_busy: assert property (@(posedge clock) disable iff (reset)
      (rd_v_ff || mul_v_ff) |-> (state_ff == ST_RUN || state_ff == ST_WAIT))
      else $error("accumulation pipeline active while idle");

   // An impulse is only reported together with a firing that cleared the potential.
   a_impulse_fires: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.impulse != IMP_NONE)
         |-> (rsp_data_ff.fired && rsp_data_ff.potential == 32'sd0))
      else $error("impulse without firing");

endmodule
